// ===== rtl/lkv_pkg.sv =====
// Shared constants, types and codes for the LRU key-value cache.
// No dependencies; every other file refers to this package by scoped names.
package lkv_pkg;

   localparam int ENTRIES    = 16;
   localparam int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W      = $clog2(ENTRIES + 1);
   localparam int KEY_W      = 32;
   localparam int DATA_W     = 32;
   localparam int CAP_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);
   localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);
   localparam logic [RANK_W-1:0]    RANK_MAX     = RANK_W'(ENTRIES - 1);
   localparam logic [DATA_W-1:0]    MISS_VALUE   = '1;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // broadcast to every cell
   typedef struct packed {
      logic                     look;
      logic                     exec;
      logic                     put;
      logic                     hit;
      logic                     evict_en;
      logic [RANK_W-1:0]        hit_rank;
      logic [RANK_W-1:0]        lru_rank;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   // lookup result rippled from cell to cell
   typedef struct packed {
      logic                     hit;
      logic [RANK_W-1:0]        rank;
      logic signed [DATA_W-1:0] data;
   } chain_type;

   typedef struct packed {
      logic valid;
      logic match;
   } stat_type;

endpackage

// ===== rtl/lkv_if.sv =====
// Request and response channel interfaces for the LRU key-value cache.
// Depends on lkv_pkg for field widths.
interface lkv_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic signed [lkv_pkg::KEY_W-1:0]  lookup_key;
   logic signed [lkv_pkg::DATA_W-1:0] write_value;

   modport source (output valid, action, lookup_key, write_value, input ready);
   modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

interface lkv_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              found;
   logic signed [lkv_pkg::DATA_W-1:0] read_value;

   modport source (output valid, found, read_value, input ready);
   modport sink   (input valid, found, read_value, output ready);
endinterface

// ===== rtl/lkv_cell.sv =====
// One cache entry: key, data, valid and recency rank, plus its link in the
// lookup and free-slot chains. Depends on lkv_pkg.
module lkv_cell (
   input  logic               clock,
   input  logic               reset,
   input  lkv_pkg::cmd_type   cmd,
   input  lkv_pkg::chain_type chain_in,
   output lkv_pkg::chain_type chain_out,
   input  logic               taken_in,
   output logic               taken_out,
   output lkv_pkg::stat_type  stat
);

   logic                                valid_ff, valid_in;
   logic                                match_ff, match_in;
   logic [lkv_pkg::RANK_W-1:0]          rank_ff, rank_in;
   logic signed [lkv_pkg::KEY_W-1:0]    key_ff, key_in;
   logic signed [lkv_pkg::DATA_W-1:0]   data_ff, data_in;
   logic                                hit_now;
   logic                                evict;
   logic                                free;
   logic                                take;

   assign hit_now = valid_ff && (key_ff == cmd.key);

   always_comb begin
      chain_out.hit  = chain_in.hit | hit_now;
      chain_out.rank = chain_in.rank | (hit_now ? rank_ff : '0);
      chain_out.data = chain_in.data | (hit_now ? data_ff : '0);
   end

   // the least recent entry holds the highest rank, occupied count minus one
   assign evict     = cmd.evict_en && valid_ff && (rank_ff == cmd.lru_rank);
   assign free      = !valid_ff || evict;
   assign take      = cmd.put && !cmd.hit && free && !taken_in;
   assign taken_out = taken_in || free;

   assign stat.valid = valid_ff;
   assign stat.match = match_ff;

   always_comb begin
      valid_in = valid_ff;
      match_in = cmd.look ? hit_now : match_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (cmd.exec) begin
         if (cmd.hit) begin
            if (match_ff) begin
               rank_in = '0;
               if (cmd.put) begin
                  data_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < cmd.hit_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end else if (cmd.put) begin
            if (take) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               data_in  = cmd.value;
               rank_in  = '0;
            end else if (evict) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff && (rank_ff != lkv_pkg::RANK_MAX)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

endmodule

// ===== rtl/lkv_csr.sv =====
// APB-style register slave holding the capacity register; also produces
// the clamped capacity used by the eviction check. Depends on lkv_pkg.
module lkv_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lkv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lkv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic [lkv_pkg::OCC_W-1:0]          cap_eff
);

   logic [lkv_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                      sel_cap;
   logic [31:0]               cap_wide;

   assign pready  = 1'b1;
   assign sel_cap = (paddr[lkv_pkg::CSR_ADDR_W-1:2] == lkv_pkg::REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && sel_cap) begin
         cap_in = pwdata[lkv_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign prdata = sel_cap ? lkv_pkg::CSR_DATA_W'(cap_ff) : '0;

   // zero acts as one, anything above the entry count saturates
   assign cap_wide = 32'(cap_ff);
   always_comb begin
      if (cap_wide == 32'd0) begin
         cap_eff = lkv_pkg::OCC_W'(1);
      end else if (cap_wide > 32'(lkv_pkg::ENTRIES)) begin
         cap_eff = lkv_pkg::OCC_W'(lkv_pkg::ENTRIES);
      end else begin
         cap_eff = lkv_pkg::OCC_W'(cap_wide);
      end
   end

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_req_if/lkv_rsp_if, lkv_cell and lkv_csr.
// Usage:
//   req carries one word per access: action (get or put), lookup_key and
//   write_value. rsp returns one word per access: found and read_value
//   (stored value on a get hit, all ones on a get miss, zero for a put).
//   The capacity register sits at byte address 0 of the APB-style port and
//   may be written only while no access is in flight.
// Timing:
//   An access passes through a lookup state, where every cell compares its key
//   and the hit, rank and data ripple down the cell row into registers, and
//   then an update state, where all cells age, evict or fill at once and the
//   response register loads. A new request is taken in the update state,
//   not in lookup, as the lookup/update pair shares the single cell row.
// Reset: all entries become invalid, the occupied count clears and the
//   capacity returns to 16. No clearing pass is needed.
// Stall: while a response waits on rsp.ready the update state holds, and
//   req.ready stays low there until the response register can be refilled.
module lru_key_value_cache_unit (
   input  logic                               clock,
   input  logic                               reset,
   lkv_req_if.sink                            req,
   lkv_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lkv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [lkv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [lkv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type                           state_ff, state_in;
   logic                                act_ff, act_in;
   logic signed [lkv_pkg::KEY_W-1:0]    key_ff, key_in;
   logic signed [lkv_pkg::DATA_W-1:0]   val_ff, val_in;
   logic                                hit_ff, hit_in;
   logic [lkv_pkg::RANK_W-1:0]          hit_rank_ff, hit_rank_in;
   logic signed [lkv_pkg::DATA_W-1:0]   hit_data_ff, hit_data_in;
   logic [lkv_pkg::OCC_W-1:0]           occ_ff, occ_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic signed [lkv_pkg::DATA_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                                out_free;
   logic                                exec_go;
   logic                                accept;
   logic                                evict_en;
   logic [lkv_pkg::OCC_W-1:0]           cap_eff;
   lkv_pkg::cmd_type                    cmd;
   lkv_pkg::chain_type                  chain [0:lkv_pkg::ENTRIES];
   logic                                taken [0:lkv_pkg::ENTRIES];
   lkv_pkg::stat_type                   stat  [0:lkv_pkg::ENTRIES-1];
   logic [lkv_pkg::ENTRIES-1:0]         valid_vec;
   logic [lkv_pkg::ENTRIES-1:0]         match_vec;

   lkv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cap_eff (cap_eff)
   );

   // handshake and sequencing
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign exec_go   = (state_ff == ST_EXEC) && out_free;
   assign req.ready = (state_ff == ST_IDLE) || exec_go;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = accept ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      act_in = act_ff;
      key_in = key_ff;
      val_in = val_ff;
      if (accept) begin
         act_in = req.action;
         key_in = req.lookup_key;
         val_in = req.write_value;
      end
   end

   // cell row
   assign evict_en = (act_ff == lkv_pkg::ACT_PUT) && !hit_ff && (occ_ff >= cap_eff);

   always_comb begin
      cmd.look     = (state_ff == ST_LOOK);
      cmd.exec     = exec_go;
      cmd.put      = (act_ff == lkv_pkg::ACT_PUT);
      cmd.hit      = hit_ff;
      cmd.evict_en = evict_en;
      cmd.hit_rank = hit_rank_ff;
      cmd.lru_rank = lkv_pkg::RANK_W'(occ_ff - 1'b1);
      cmd.key      = key_ff;
      cmd.value    = val_ff;
   end

   assign chain[0] = '0;
   assign taken[0] = 1'b0;

   for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .taken_in  (taken[i]),
         .taken_out (taken[i+1]),
         .stat      (stat[i])
      );
      assign valid_vec[i] = stat[i].valid;
      assign match_vec[i] = stat[i].match;
   end

   // capture the end of the lookup chain
   always_comb begin
      hit_in      = hit_ff;
      hit_rank_in = hit_rank_ff;
      hit_data_in = hit_data_ff;
      if (state_ff == ST_LOOK) begin
         hit_in      = chain[lkv_pkg::ENTRIES].hit;
         hit_rank_in = chain[lkv_pkg::ENTRIES].rank;
         hit_data_in = chain[lkv_pkg::ENTRIES].data;
      end
   end

   // a new key always finds a slot, so a fill adds one and an eviction takes one
   always_comb begin
      occ_in = occ_ff;
      if (exec_go && (act_ff == lkv_pkg::ACT_PUT) && !hit_ff) begin
         occ_in = occ_ff + 1'b1 - lkv_pkg::OCC_W'(evict_en);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         if (act_ff == lkv_pkg::ACT_PUT) begin
            rsp_value_in = '0;
         end else if (hit_ff) begin
            rsp_value_in = hit_data_ff;
         end else begin
            rsp_value_in = lkv_pkg::MISS_VALUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      hit_ff       <= hit_in;
      hit_rank_ff  <= hit_rank_in;
      hit_data_ff  <= hit_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.read_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_occ_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(occ_ff))
      else $error("occupied count differs from number of valid entries");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $onehot0(match_vec))
      else $error("key matched more than one entry");

   a_hit_has_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (hit_ff == (match_vec != '0)))
      else $error("registered hit disagrees with cell match flags");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("update cycle did not load a response");
`endif

endmodule

// ===== sim/lru_key_value_cache_unit_tb.sv =====
// Self-checking testbench for the LRU key-value cache: drives get/put words,
// predicts every reply from its own LRU table and checks the replies in order.
// Depends on lkv_pkg, lkv_req_if/lkv_rsp_if and lru_key_value_cache_unit.
module lru_key_value_cache_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 64;
   localparam int PHASE_WORDS = 155;
   localparam int PLAN_LEN    = 10;
   localparam logic [lkv_pkg::REG_IDX_W-1:0]  REG_SPARE  = lkv_pkg::REG_CAPACITY + 1'b1;
   localparam logic [lkv_pkg::CSR_ADDR_W-1:0] CAP_ADDR   = {lkv_pkg::REG_CAPACITY, 2'b00};
   localparam logic [lkv_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};
   localparam logic [lkv_pkg::KEY_W-1:0]      KEY_MIN    = 32'h8000_0000;
   localparam logic [lkv_pkg::KEY_W-1:0]      KEY_MAX    = 32'h7FFF_FFFF;

   typedef struct packed {
      logic                       action;
      logic [lkv_pkg::KEY_W-1:0]  key;
      logic [lkv_pkg::DATA_W-1:0] value;
   } access_type;

   typedef struct packed {
      logic                       found;
      logic [lkv_pkg::DATA_W-1:0] read_value;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [lkv_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [lkv_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [lkv_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   logic       drv_valid = 1'b0;
   access_type drv_word = '0;
   logic       rsp_rdy = 1'b0;
   logic       req_taken = 1'b0;
   logic       idle_en = 1'b1;

   lkv_req_if req_ch ();
   lkv_rsp_if rsp_ch ();

   assign req_ch.valid       = drv_valid;
   assign req_ch.action      = drv_word.action;
   assign req_ch.lookup_key  = drv_word.key;
   assign req_ch.write_value = drv_word.value;
   assign rsp_ch.ready       = rsp_rdy;

   lru_key_value_cache_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   access_type access_q[$];
   reply_type  due_replies[$];
   int errors = 0;
   int replies_seen = 0;
   int hits_seen = 0;
   int puts_sent = 0;
   int cycle_count = 0;

   // Shadow LRU table
   logic                       slot_live[lkv_pkg::ENTRIES];
   logic [lkv_pkg::KEY_W-1:0]  slot_key[lkv_pkg::ENTRIES];
   logic [lkv_pkg::DATA_W-1:0] slot_data[lkv_pkg::ENTRIES];
   int                         slot_age[lkv_pkg::ENTRIES];
   int                         live_count = 0;
   logic [lkv_pkg::CAP_W-1:0]  cap_setting = lkv_pkg::CAP_RESET;

   initial begin
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
         slot_live[i] = 1'b0;
         slot_age[i]  = 0;
      end
   end

   function automatic void make_newest(int idx);
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
         if (slot_live[i] && i != idx && slot_age[i] < slot_age[idx])
            slot_age[i]++;
      slot_age[idx] = 0;
   endfunction

   function automatic void drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
         if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
            victim = i;
      if (victim >= 0) begin
         slot_live[victim] = 1'b0;
         slot_age[victim]  = 0;
         if (live_count > 0)
            live_count--;
      end
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < lkv_pkg::ENTRIES; i++)
         if (!slot_live[i])
            return i;
      return -1;
   endfunction

   function automatic int effective_cap(logic [lkv_pkg::CAP_W-1:0] c);
      if (c == 0)
         return 1;
      if (c > lkv_pkg::ENTRIES)
         return lkv_pkg::ENTRIES;
      return int'(c);
   endfunction

   function automatic reply_type apply_access(access_type a);
      reply_type r;
      int hit;
      int slot;
      hit = -1;
      for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--)
         if (slot_live[i] && slot_key[i] == a.key)
            hit = i;
      r.found = (hit >= 0);
      r.read_value = '0;
      if (a.action == lkv_pkg::ACT_GET) begin
         if (hit >= 0) begin
            r.read_value = slot_data[hit];
            make_newest(hit);
         end else begin
            r.read_value = lkv_pkg::MISS_VALUE;
         end
      end else if (hit >= 0) begin
         slot_data[hit] = a.value;
         make_newest(hit);
      end else begin
         if (live_count >= effective_cap(cap_setting))
            drop_oldest();
         slot = free_slot();
         if (slot < 0) begin
            drop_oldest();
            slot = free_slot();
         end
         if (slot >= 0) begin
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
               if (slot_live[i] && slot_age[i] < lkv_pkg::ENTRIES - 1)
                  slot_age[i]++;
            slot_live[slot] = 1'b1;
            slot_key[slot]  = a.key;
            slot_data[slot] = a.value;
            slot_age[slot]  = 0;
            live_count++;
         end
      end
      return r;
   endfunction

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d replies pending", cycle_count,
                  due_replies.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Request driver: hold a word until taken, then advance or insert a gap
   int gap_cnt = 0;
   always @(negedge clock) begin
      if (!reset && (!drv_valid || req_taken)) begin
         if (gap_cnt != 0) begin
            gap_cnt <= gap_cnt - 1;
            drv_valid <= 1'b0;
         end else if (access_q.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
            gap_cnt <= $urandom_range(0, 3);
            drv_valid <= 1'b0;
         end else if (access_q.size() != 0) begin
            drv_word <= access_q.pop_front();
            drv_valid <= 1'b1;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Reply ready: random stalls plus one long hold-off to back up the block
   int stall_cnt = 0;
   int hold_cnt = 0;
   logic hold_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_rdy <= 1'b0;
         end else if (!hold_done && replies_seen >= 400) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES - 1;
            rsp_rdy <= 1'b0;
         end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_rdy <= 1'b0;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_cnt <= $urandom_range(0, 3);
            rsp_rdy <= 1'b0;
         end else begin
            rsp_rdy <= 1'b1;
         end
      end
   end

   // Monitor: check replies first, then predict the word taken at this edge
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.found = rsp_ch.found;
            got.read_value = rsp_ch.read_value;
            replies_seen <= replies_seen + 1;
            if (got.found)
               hits_seen <= hits_seen + 1;
            if (due_replies.size() == 0) begin
               errors++;
               $display("%0t: unexpected reply, expected none actual found %0b read_value %h",
                        $time, got.found, got.read_value);
            end else begin
               want = due_replies.pop_front();
               if (got.found !== want.found) begin
                  errors++;
                  $display("%0t: found mismatch, expected %0b actual %0b", $time,
                           want.found, got.found);
               end
               if (got.read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value mismatch, expected %h actual %h", $time,
                           want.read_value, got.read_value);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            due_replies.push_back(apply_access(drv_word));
            if (drv_word.action == lkv_pkg::ACT_PUT)
               puts_sent <= puts_sent + 1;
         end
      end
   end

   task automatic csr_write(input logic [lkv_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [lkv_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == CAP_ADDR)
         cap_setting = data[lkv_pkg::CAP_W-1:0];
   endtask

   task automatic csr_check_capacity();
      logic [lkv_pkg::CSR_DATA_W-1:0] got;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CAP_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== lkv_pkg::CSR_DATA_W'(cap_setting)) begin
         errors++;
         $display("%0t: capacity readback, expected %h actual %h", $time,
                  lkv_pkg::CSR_DATA_W'(cap_setting), got);
      end
   endtask

   task automatic wait_idle();
      while (access_q.size() != 0 || drv_valid || due_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_access(logic act, logic [lkv_pkg::KEY_W-1:0] key,
                              logic [lkv_pkg::DATA_W-1:0] val);
      access_type a;
      a.action = act;
      a.key = key;
      a.value = val;
      access_q.push_back(a);
   endtask

   function automatic logic [lkv_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 11))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // Mostly keys from a pool a little larger than the capacity, so that hits,
   // updates and evictions all occur; a few fresh keys add misses.
   task automatic queue_random(int count, logic [lkv_pkg::CAP_W-1:0] c);
      logic [lkv_pkg::KEY_W-1:0] pool[$];
      logic [lkv_pkg::KEY_W-1:0] key;
      logic [lkv_pkg::DATA_W-1:0] val;
      int pool_size;
      pool_size = effective_cap(c) + $urandom_range(1, 4);
      for (int i = 0; i < pool_size; i++)
         pool.push_back(pick_key());
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0)
            key = $urandom();
         else
            key = pool[$urandom_range(0, pool_size - 1)];
         val = ($urandom_range(0, 7) == 0) ? lkv_pkg::MISS_VALUE
                                           : lkv_pkg::DATA_W'($urandom());
         push_access($urandom_range(0, 1) ? lkv_pkg::ACT_PUT : lkv_pkg::ACT_GET, key, val);
      end
   endtask

   initial begin
      logic [lkv_pkg::CSR_DATA_W-1:0] cap_plan[PLAN_LEN];
      cap_plan = '{32'hFFFF_FFE1, 32'h0, 32'h1F, 32'h3, 32'h10,
                   32'h2, 32'h7, 32'h11, 32'hC, 32'h10};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check_capacity();
      // Empty table, extreme keys and values, a stored all-ones value
      push_access(lkv_pkg::ACT_GET, '0, '0);
      push_access(lkv_pkg::ACT_PUT, KEY_MIN, KEY_MAX);
      push_access(lkv_pkg::ACT_PUT, KEY_MAX, KEY_MIN);
      push_access(lkv_pkg::ACT_PUT, '1, '1);
      push_access(lkv_pkg::ACT_PUT, '0, '0);
      push_access(lkv_pkg::ACT_GET, '1, 32'h1234_5678);
      push_access(lkv_pkg::ACT_GET, KEY_MIN, '0);
      push_access(lkv_pkg::ACT_GET, KEY_MAX, '0);
      push_access(lkv_pkg::ACT_GET, 32'hFFFF_FFFE, '0);
      push_access(lkv_pkg::ACT_PUT, KEY_MIN, 32'h5A5A_5A5A);
      push_access(lkv_pkg::ACT_GET, KEY_MIN, '0);
      push_access(lkv_pkg::ACT_GET, '0, '1);
      push_access(lkv_pkg::ACT_GET, 32'h0000_0001, '0);
      wait_idle();

      // Writes to the unused register slot must leave capacity alone
      csr_write(SPARE_ADDR, 32'h3);
      csr_check_capacity();

      for (int p = 0; p < PLAN_LEN; p++) begin
         wait_idle();
         csr_write(CAP_ADDR, cap_plan[p]);
         csr_check_capacity();
         idle_en = (p != PLAN_LEN - 1);
         queue_random(PHASE_WORDS, cap_plan[p][lkv_pkg::CAP_W-1:0]);
      end
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Checked %0d replies (%0d hits, %0d puts) over %0d capacity settings,",
               replies_seen, hits_seen, puts_sent, PLAN_LEN + 1);
      $display("including zero, saturated and shrunk capacity plus a long reply stall.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
